### src/gfq_pkg.sv
package gfq_pkg;

	localparam int CAPACITY    = 64;
	localparam int NUM_GROUPS  = 16;
	localparam int ID_BITS     = 16;
	localparam int GROUP_BITS  = 5;
	localparam int STATUS_BITS = 3;

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FCNT_W = $clog2(CAPACITY + 1);
	localparam int GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int OCNT_W = $clog2(NUM_GROUPS + 1);

	typedef enum logic [STATUS_BITS-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] v);
		return (v == SLOT_W'(CAPACITY - 1)) ? '0 : v + SLOT_W'(1);
	endfunction

	function automatic logic [GRP_W-1:0] grp_inc(input logic [GRP_W-1:0] v);
		return (v == GRP_W'(NUM_GROUPS - 1)) ? '0 : v + GRP_W'(1);
	endfunction

endpackage

### src/grouped_fifo_queue.sv
// Result: an accepted item's status and id are registered in the output register.
// Throughput: one item per cycle while results are taken; each item is one pass
// through the group tables, slot memories read ahead into per-group head registers.
// Reset: counters, pointers and group sizes clear; the free list comes up full
// through a fill count, so no clearing pass runs and items are taken at once.
module grouped_fifo_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [gfq_pkg::ID_BITS-1:0]    member_id,
	input  logic [gfq_pkg::GROUP_BITS-1:0] group,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gfq_pkg::STATUS_BITS-1:0] status,
	output logic [gfq_pkg::ID_BITS-1:0]    out_id
);
	import gfq_pkg::*;

	logic [ID_BITS-1:0] slot_member_q [CAPACITY];
	logic [SLOT_W-1:0]  slot_link_q   [CAPACITY];
	logic [SLOT_W-1:0]  free_slots_q  [CAPACITY];

	logic [SLOT_W-1:0]  group_first_q [NUM_GROUPS];
	logic [SLOT_W-1:0]  group_last_q  [NUM_GROUPS];
	logic [FCNT_W-1:0]  group_size_q  [NUM_GROUPS];
	logic [ID_BITS-1:0] head_member_q [NUM_GROUPS];
	logic [SLOT_W-1:0]  head_link_q   [NUM_GROUPS];

	logic [GRP_W-1:0]   order_ring_q [NUM_GROUPS];
	logic [GRP_W-1:0]   order_front_q, order_back_q;
	logic [OCNT_W-1:0]  order_size_q;

	logic [SLOT_W-1:0]  free_rd_q, free_wr_q, free_head_q;
	logic               free_wrapped_q;
	logic [FCNT_W-1:0]  free_count_q;

	logic               pend_valid_q;
	logic [GRP_W-1:0]   pend_group_q;
	logic [ID_BITS-1:0] rd_member_q;
	logic [SLOT_W-1:0]  rd_link_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [ID_BITS-1:0] out_id_q;

	logic               fire, grp_ok, do_enq, do_deq, deq_last, pend_hit, fetch;
	logic               push, pop, wrapped_next;
	logic [31:0]        grp_ext;
	logic [GRP_W-1:0]   enq_g, cur_g;
	logic [FCNT_W-1:0]  cur_size;
	logic [SLOT_W-1:0]  cur_first, cur_last, eff_link, rd_next, wr_next;
	logic [ID_BITS-1:0] eff_member;
	status_t            res_status;

	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;

	assign grp_ext  = 32'(group) - 32'd1;
	assign grp_ok   = (group != '0) && (32'(group) <= 32'(NUM_GROUPS));
	assign enq_g    = grp_ext[GRP_W-1:0];
	assign cur_g    = kind ? order_ring_q[order_front_q] : enq_g;

	assign cur_size  = group_size_q[cur_g];
	assign cur_first = group_first_q[cur_g];
	assign cur_last  = group_last_q[cur_g];
	assign pend_hit  = pend_valid_q && (pend_group_q == cur_g);
	assign eff_member = pend_hit ? rd_member_q : head_member_q[cur_g];
	assign eff_link   = pend_hit ? rd_link_q : head_link_q[cur_g];

	assign do_enq   = fire && !kind && grp_ok && (free_count_q != '0);
	assign do_deq   = fire && kind && (order_size_q != '0);
	assign deq_last = (cur_size == FCNT_W'(1));
	assign fetch    = do_deq && !deq_last;

	assign pop  = do_enq;
	assign push = do_deq && (free_count_q < FCNT_W'(CAPACITY));
	assign rd_next = pop ? slot_inc(free_rd_q) : free_rd_q;
	assign wr_next = push ? slot_inc(free_wr_q) : free_wr_q;
	assign wrapped_next = free_wrapped_q || (push && (free_wr_q == SLOT_W'(CAPACITY - 1)));

	always_comb begin
		if (!kind) begin
			if (!grp_ok)
				res_status = ST_IGNORED;
			else if (free_count_q == '0)
				res_status = ST_DROPPED;
			else
				res_status = ST_ENQUEUED;
		end else begin
			res_status = (order_size_q == '0) ? ST_EMPTY : ST_DEQUEUED;
		end
	end

	// slot storage and one-ahead read of the next head
	always_ff @(posedge clk) begin
		if (do_enq) begin
			slot_member_q[free_head_q] <= member_id;
			if (cur_size != '0)
				slot_link_q[cur_last] <= free_head_q;
		end
		if (fetch) begin
			rd_member_q <= slot_member_q[eff_link];
			rd_link_q   <= slot_link_q[eff_link];
		end
		if (push)
			free_slots_q[free_wr_q] <= cur_first;
	end

	// head cache: pending fill, unless this item rewrites the same link
	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			head_member_q[pend_group_q] <= rd_member_q;
			if (!(do_enq && pend_hit && (cur_size == FCNT_W'(1))))
				head_link_q[pend_group_q] <= rd_link_q;
		end
		if (do_enq) begin
			if (cur_size == '0)
				head_member_q[cur_g] <= member_id;
			else if (cur_size == FCNT_W'(1))
				head_link_q[cur_g] <= free_head_q;
		end
		if (do_enq && (cur_size == '0))
			order_ring_q[order_back_q] <= cur_g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GROUPS; i++) begin
				group_first_q[i] <= '0;
				group_last_q[i]  <= '0;
				group_size_q[i]  <= '0;
			end
			order_front_q  <= '0;
			order_back_q   <= '0;
			order_size_q   <= '0;
			free_rd_q      <= '0;
			free_wr_q      <= '0;
			free_wrapped_q <= 1'b0;
			free_count_q   <= FCNT_W'(CAPACITY);
			free_head_q    <= '0;
			pend_valid_q   <= 1'b0;
			pend_group_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (do_enq) begin
				if (cur_size == '0) begin
					group_first_q[cur_g] <= free_head_q;
					order_back_q <= grp_inc(order_back_q);
					order_size_q <= order_size_q + OCNT_W'(1);
				end
				group_last_q[cur_g] <= free_head_q;
				group_size_q[cur_g] <= cur_size + FCNT_W'(1);
			end
			if (do_deq) begin
				group_size_q[cur_g] <= cur_size - FCNT_W'(1);
				if (deq_last) begin
					order_front_q <= grp_inc(order_front_q);
					order_size_q  <= order_size_q - OCNT_W'(1);
				end else begin
					group_first_q[cur_g] <= eff_link;
				end
			end

			pend_valid_q <= fetch;
			pend_group_q <= cur_g;

			free_rd_q      <= rd_next;
			free_wr_q      <= wr_next;
			free_wrapped_q <= wrapped_next;
			if (push && !pop)
				free_count_q <= free_count_q + FCNT_W'(1);
			else if (pop && !push)
				free_count_q <= free_count_q - FCNT_W'(1);

			// never-written free entries hold their own slot number
			if (push && (free_wr_q == rd_next))
				free_head_q <= cur_first;
			else if (wrapped_next || (rd_next < wr_next))
				free_head_q <= free_slots_q[rd_next];
			else
				free_head_q <= rd_next;

			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= res_status;
			out_id_q <= (res_status == ST_DEQUEUED) ? eff_member : '0;
		end
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import gfq_pkg::*;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 420;

	typedef struct packed {
		status_t                st;
		logic [ID_BITS-1:0]     id;
	} queue_reply_t;

	typedef struct {
		logic                   k;
		logic [ID_BITS-1:0]     id;
		logic [GROUP_BITS-1:0]  g;
		int                     reps;
		bit                     g_step;
		bit                     typed;
		status_t                st;
		logic [ID_BITS-1:0]     oid;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    kind = 1'b0;
	logic [ID_BITS-1:0]      member_id = '0;
	logic [GROUP_BITS-1:0]   group = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STATUS_BITS-1:0]  status;
	logic [ID_BITS-1:0]      out_id;

	queue_reply_t queue_replies[$];
	int errors = 0;
	int idle_mode = 0;
	bit hold_go = 0;
	int send_idle_pct [3] = '{31, 76, 0};
	int recv_idle_pct [3] = '{76, 31, 0};

	// predictor state: slot pool, per-group linked lists, ring of group order
	logic [ID_BITS-1:0] slot_id [CAPACITY];
	int slot_next [CAPACITY];
	int free_stack [CAPACITY];
	int free_n;
	int team_head [NUM_GROUPS];
	int team_tail [NUM_GROUPS];
	int team_cnt [NUM_GROUPS];
	int ring [NUM_GROUPS];
	int ring_rd, ring_wr, ring_n;

	dir_row_t dir_rows [21] = '{
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 1, ST_EMPTY,    16'h0000},
		'{KIND_ENQ, 16'h1111, 5'd0,  1,  0, 1, ST_IGNORED,  16'h0000},
		'{KIND_ENQ, 16'h2222, 5'd17, 1,  0, 1, ST_IGNORED,  16'h0000},
		'{KIND_ENQ, 16'hffff, 5'd31, 1,  0, 1, ST_IGNORED,  16'h0000},
		'{KIND_ENQ, 16'h0000, 5'd1,  1,  0, 1, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'hffff, 5'd16, 1,  0, 1, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'h1234, 5'd1,  1,  0, 1, ST_ENQUEUED, 16'h0000},
		'{KIND_DEQ, 16'hffff, 5'd31, 1,  0, 1, ST_DEQUEUED, 16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 1, ST_EMPTY,    16'h0000},
		'{KIND_DEQ, 16'hffff, 5'd31, 1,  0, 1, ST_EMPTY,    16'h0000},
		'{KIND_ENQ, 16'ha5a5, 5'd3,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'h5a5a, 5'd7,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'h0001, 5'd3,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'h8000, 5'd1,  62, 1, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_ENQ, 16'h7777, 5'd5,  1,  0, 1, ST_DROPPED,  16'h0000},
		'{KIND_ENQ, 16'h0000, 5'd0,  1,  0, 1, ST_IGNORED,  16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  64, 0, 0, ST_ENQUEUED, 16'h0000},
		'{KIND_DEQ, 16'h0000, 5'd0,  1,  0, 1, ST_EMPTY,    16'h0000}
	};

	grouped_fifo_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.member_id (member_id),
		.group     (group),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_id    (out_id)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic team_queue_next(input logic k, input logic [ID_BITS-1:0] id,
			input logic [GROUP_BITS-1:0] g, output queue_reply_t r);
		int gi;
		int s;
		r.st = ST_EMPTY;
		r.id = '0;
		if (k == KIND_ENQ) begin
			if (g == 0 || g > NUM_GROUPS) begin
				r.st = ST_IGNORED;
			end else if (free_n == 0) begin
				r.st = ST_DROPPED;
			end else begin
				r.st = ST_ENQUEUED;
				gi = int'(g) - 1;
				free_n--;
				s = free_stack[free_n];
				slot_id[s] = id;
				slot_next[s] = 0;
				if (team_cnt[gi] == 0) begin
					team_head[gi] = s;
					ring[ring_wr] = gi;
					ring_wr = (ring_wr + 1) % NUM_GROUPS;
					ring_n++;
				end else begin
					slot_next[team_tail[gi]] = s;
				end
				team_tail[gi] = s;
				team_cnt[gi]++;
			end
		end else if (ring_n != 0) begin
			gi = ring[ring_rd];
			s = team_head[gi];
			r.st = ST_DEQUEUED;
			r.id = slot_id[s];
			team_cnt[gi]--;
			if (team_cnt[gi] == 0) begin
				ring_rd = (ring_rd + 1) % NUM_GROUPS;
				ring_n--;
			end else begin
				team_head[gi] = slot_next[s];
			end
			free_stack[free_n] = s;
			free_n++;
		end
	endtask

	task automatic offer_item(input logic k, input logic [ID_BITS-1:0] id,
			input logic [GROUP_BITS-1:0] g, input bit typed, input status_t t_st,
			input logic [ID_BITS-1:0] t_id);
		queue_reply_t r;
		bit took;
		while ($urandom_range(99) < send_idle_pct[idle_mode]) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		member_id <= id;
		group <= g;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		team_queue_next(k, id, g, r);
		if (typed) begin
			r.st = t_st;
			r.id = t_id;
		end
		queue_replies.push_back(r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (queue_replies.size() != 0);
	endtask

	initial begin
		dir_row_t row;
		logic k;
		logic [ID_BITS-1:0] id;
		logic [GROUP_BITS-1:0] g;
		int mode;
		int pct_enq;
		int r;
		for (int i = 0; i < CAPACITY; i++) begin
			free_stack[i] = i;
			slot_next[i] = 0;
		end
		free_n = CAPACITY;
		for (int i = 0; i < NUM_GROUPS; i++) begin
			team_head[i] = 0;
			team_tail[i] = 0;
			team_cnt[i] = 0;
			ring[i] = 0;
		end
		ring_rd = 0;
		ring_wr = 0;
		ring_n = 0;
		mode = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[j]) begin
			row = dir_rows[j];
			for (int i = 0; i < row.reps; i++) begin
				id = ID_BITS'(int'(row.id) + i);
				g = row.g_step ? GROUP_BITS'((int'(row.g) - 1 + i) % NUM_GROUPS + 1) : row.g;
				offer_item(row.k, id, g, row.typed, row.st, row.oid);
			end
		end
		wait_drained();

		hold_go = 1;
		for (int phase = 0; phase < 3; phase++) begin
			idle_mode = phase;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// blocks of fill, drain and balanced traffic
				if (n % 40 == 0)
					mode = $urandom_range(2);
				pct_enq = (mode == 0) ? 50 : (mode == 1) ? 85 : 20;
				k = ($urandom_range(99) < pct_enq) ? KIND_ENQ : KIND_DEQ;
				id = ID_BITS'($urandom);
				r = $urandom_range(99);
				if (r < 60)
					g = GROUP_BITS'($urandom_range(4, 1));
				else if (r < 88)
					g = GROUP_BITS'($urandom_range(NUM_GROUPS, 1));
				else
					g = GROUP_BITS'($urandom_range(31, 0));
				offer_item(k, id, g, 1'b0, ST_ENQUEUED, '0);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct[idle_mode]);
			end
		end
	end

	initial begin
		queue_reply_t want;
		bit took;
		logic [STATUS_BITS-1:0] st_s;
		logic [ID_BITS-1:0] id_s;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			took = out_valid && out_ready;
			st_s = status;
			id_s = out_id;
			@(posedge clk);
			if (took) begin
				if (queue_replies.size() == 0) begin
					$error("unexpected item: status %0d out_id %h", st_s, id_s);
					errors++;
				end else begin
					want = queue_replies.pop_front();
					if (st_s !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, st_s);
						errors++;
					end
					if (id_s !== want.id) begin
						$error("out_id: expected %h, actual %h", want.id, id_s);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
